// File: rtl/pbs_pkg.sv
package pbs_pkg;

	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_ALLOC    = 3'd1;
	localparam logic [2:0] CMD_SETSTATE = 3'd2;
	localparam logic [2:0] CMD_SETPRIO  = 3'd3;
	localparam logic [2:0] CMD_PICK     = 3'd4;

	localparam logic [2:0] ST_UNUSED   = 3'd0;
	localparam logic [2:0] ST_USED     = 3'd1;
	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING  = 3'd4;
	localparam logic [2:0] ST_ZOMBIE   = 3'd5;

	localparam logic [1:0] REG_CAP = 2'd0;
	localparam logic [1:0] REG_ISP = 2'd1;
	localparam logic [1:0] REG_IBI = 2'd2;

	localparam logic [6:0] CAP_RESET = 7'd100;
	localparam logic [6:0] ISP_RESET = 7'd50;
	localparam logic [6:0] IBI_RESET = 7'd15;

	localparam logic [6:0] BI_ONE = 7'd50;
	localparam logic [6:0] BI_TWO = 7'd100;

endpackage

// File: rtl/pbs_ram.sv
module pbs_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/pbs_bi_unit.sv
module pbs_bi_unit #(
	parameter int CB = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CB-1:0] run,
	input  logic [CB-1:0] slp,
	input  logic [CB-1:0] rdy,
	output logic [6:0]    bi
);
	import pbs_pkg::*;

	logic          pos_q;
	logic [CB-1:0] run_q;
	logic [CB+2:0] lim_q;
	logic [CB:0]   tsum;
	logic [CB-1:0] diff;

	assign tsum = {1'b0, slp} + {1'b0, rdy};
	assign diff = run - slp;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q <= (run > slp) && (diff > rdy);
			run_q <= run;
			lim_q <= (CB+3)'(tsum) + (CB+3)'({tsum, 1'b0}) + (CB+3)'(2);
		end
	end

	assign bi = !pos_q ? 7'd0 : (({3'b000, run_q} >= lim_q) ? BI_TWO : BI_ONE);

endmodule

// File: rtl/priority_based_scheduler_core.sv
// Task-slot scheduler with dynamic priority.
// Input stream s_*: one beat is one command (tick, allocate, set state,
// set priority, pick). Output stream m_*: exactly one result beat per
// command. Config port cfg_*: write priority cap, initial static priority
// and initial behaviour index; write only while the block is idle.
// All slot data sits in one single-port-write RAM, one word per slot, and
// one behaviour-index unit is shared by set priority and pick.
// Allocate writes the slot word; unknown or out-of-range commands go
// straight to the result. Set state reads, then rewrites the slot; set
// priority does the same but leaves an unused slot alone. Tick rewrites
// every slot in turn; pick rates each runnable slot, then marks the best.
// s_tready is high only when idle; one command is worked at a time.
// After reset a clearing pass writes every slot word,
// with s_tready low. A stalled result waits in the output register; the
// next command is taken meanwhile, its result held until that beat leaves.
module priority_based_scheduler_core #(
	parameter int NUM_SLOTS  = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[2:0], slot[8:3], new_state[11:9], priority_req[18:12]
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// chosen_slot[5:0], found[6], old_priority[13:7], should_yield[14]
	output logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [6:0]  cfg_wdata
);
	import pbs_pkg::*;

	localparam int AW = $clog2(NUM_SLOTS);
	localparam int CB = COUNT_BITS;
	localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ALLOC = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_EV1   = 4'd4;
	localparam logic [3:0] S_EV2   = 4'd5;
	localparam logic [3:0] S_PKRD  = 4'd6;
	localparam logic [3:0] S_PKWR  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	typedef struct packed {
		logic [2:0]    st;
		logic [CB-1:0] run;
		logic [CB-1:0] slp;
		logic [CB-1:0] rdy;
		logic [6:0]    sp;
		logic [6:0]    bi;
		logic [6:0]    dp;
		logic [CB-1:0] ts;
		logic [CB-1:0] ct;
	} entry_t;

	localparam int EW = $bits(entry_t);

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		sat_inc = (&v) ? v : v + CB'(1);
	endfunction

	logic [3:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [2:0]    cmd_q;
	logic [2:0]    nst_q;
	logic [6:0]    preq_q;
	logic [6:0]    cap_q, isp_q, ibi_q;
	logic [CB-1:0] tick_q;
	logic          best_v_q;
	logic [AW-1:0] best_idx_q;
	logic [6:0]    best_dp_q;
	logic [CB-1:0] best_ts_q, best_ct_q;
	logic [5:0]    res_slot_q;
	logic          res_found_q, res_yield_q;
	logic [6:0]    res_old_q;
	logic          out_v_q;
	logic [15:0]   out_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	entry_t        rd, wr;
	logic [6:0]    ubi, bi_new, sp_src, dp_new;
	logic [7:0]    dsum;
	logic          better, accept, in_ok, last, out_load;
	logic [2:0]    in_cmd, in_nst;
	logic [5:0]    in_slot;
	logic [6:0]    in_preq;

	assign in_cmd  = s_tdata[2:0];
	assign in_slot = s_tdata[8:3];
	assign in_nst  = s_tdata[11:9];
	assign in_preq = s_tdata[18:12];
	assign in_ok   = 32'(in_slot) < NUM_SLOTS;
	assign s_tready = (state_q == S_IDLE);
	assign accept  = s_tvalid && s_tready;
	assign last    = (idx_q == LAST);
	assign rd      = entry_t'(ram_rdata);

	pbs_ram #(.W(EW), .D(NUM_SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	pbs_bi_unit #(.CB(CB)) u_bi (
		.clk(clk), .en(state_q == S_EV1), .run(rd.run), .slp(rd.slp),
		.rdy(rd.rdy), .bi(ubi)
	);

	always_comb begin
		if (cmd_q == CMD_SETPRIO) begin
			bi_new = (rd.run == '0 && rd.slp == '0) ? ibi_q : ubi;
			sp_src = preq_q;
		end else begin
			bi_new = (rd.run != '0 || rd.slp != '0) ? ubi : rd.bi;
			sp_src = rd.sp;
		end
		dsum = {1'b0, sp_src} + {1'b0, bi_new};
		dp_new = (dsum > {1'b0, cap_q}) ? cap_q : dsum[6:0];
		better = !best_v_q || dp_new < best_dp_q ||
			(dp_new == best_dp_q && rd.ts < best_ts_q) ||
			(dp_new == best_dp_q && rd.ts == best_ts_q && rd.ct < best_ct_q);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = idx_q;
		ram_raddr = idx_q;
		wr = rd;
		case (state_q)
			S_CLR: begin
				ram_we = 1'b1;
				wr = '0;
			end
			S_ALLOC: begin
				ram_we = 1'b1;
				wr = '0;
				wr.st = ST_USED;
				wr.sp = isp_q;
				wr.bi = ibi_q;
				wr.ct = tick_q;
			end
			S_RD: ram_re = 1'b1;
			S_EV1: begin
				if (cmd_q == CMD_TICK) begin
					ram_we = 1'b1;
					if (rd.st == ST_RUNNING) wr.run = sat_inc(rd.run);
					else if (rd.st == ST_SLEEPING) wr.slp = sat_inc(rd.slp);
					else if (rd.st == ST_RUNNABLE) wr.rdy = sat_inc(rd.rdy);
				end else if (cmd_q == CMD_SETSTATE) begin
					ram_we = 1'b1;
					wr.st = nst_q;
				end
			end
			S_EV2: begin
				ram_we = 1'b1;
				wr.bi = bi_new;
				wr.dp = dp_new;
				if (cmd_q == CMD_SETPRIO) begin
					wr.sp = preq_q;
					wr.run = '0;
					wr.slp = '0;
				end
			end
			S_PKRD: begin
				ram_re = 1'b1;
				ram_raddr = best_idx_q;
			end
			S_PKWR: begin
				ram_we = 1'b1;
				ram_waddr = best_idx_q;
				wr.ts = sat_inc(rd.ts);
				wr.st = ST_RUNNING;
			end
			default: ;
		endcase
		ram_wdata = wr;
	end

	assign out_load = (state_q == S_OUT) && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			cmd_q <= CMD_TICK;
			cap_q <= CAP_RESET;
			isp_q <= ISP_RESET;
			ibi_q <= IBI_RESET;
			tick_q <= '0;
			best_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_CAP: cap_q <= cfg_wdata;
					REG_ISP: isp_q <= cfg_wdata;
					REG_IBI: ibi_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					idx_q <= last ? '0 : idx_q + AW'(1);
					if (last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						best_v_q <= 1'b0;
						case (in_cmd)
							CMD_TICK, CMD_PICK: begin
								idx_q <= '0;
								state_q <= S_RD;
							end
							CMD_ALLOC: begin
								idx_q <= AW'(in_slot);
								state_q <= in_ok ? S_ALLOC : S_OUT;
							end
							CMD_SETSTATE: begin
								idx_q <= AW'(in_slot);
								state_q <= (in_ok && in_nst <= ST_ZOMBIE) ? S_RD : S_OUT;
							end
							CMD_SETPRIO: begin
								idx_q <= AW'(in_slot);
								state_q <= in_ok ? S_RD : S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ALLOC: state_q <= S_OUT;
				S_RD: state_q <= S_EV1;
				S_EV1: begin
					case (cmd_q)
						CMD_SETSTATE: state_q <= S_OUT;
						CMD_SETPRIO: state_q <= (rd.st == ST_UNUSED) ? S_OUT : S_EV2;
						default: begin
							if (cmd_q == CMD_PICK && rd.st == ST_RUNNABLE) begin
								state_q <= S_EV2;
							end else if (!last) begin
								idx_q <= idx_q + AW'(1);
								state_q <= S_RD;
							end else if (cmd_q == CMD_TICK) begin
								tick_q <= sat_inc(tick_q);
								state_q <= S_OUT;
							end else begin
								state_q <= best_v_q ? S_PKRD : S_OUT;
							end
						end
					endcase
				end
				S_EV2: begin
					if (cmd_q == CMD_SETPRIO) begin
						state_q <= S_OUT;
					end else begin
						if (better) best_v_q <= 1'b1;
						if (!last) begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_RD;
						end else begin
							state_q <= (best_v_q || better) ? S_PKRD : S_OUT;
						end
					end
				end
				S_PKRD: state_q <= S_PKWR;
				S_PKWR: state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nst_q <= in_nst;
			preq_q <= in_preq;
			res_slot_q <= '0;
			res_found_q <= 1'b0;
			res_old_q <= '0;
			res_yield_q <= 1'b0;
		end
		if (state_q == S_EV2) begin
			if (cmd_q == CMD_SETPRIO) begin
				res_found_q <= 1'b1;
				res_old_q <= rd.sp;
				res_yield_q <= rd.dp > dp_new;
			end else if (better) begin
				best_idx_q <= idx_q;
				best_dp_q <= dp_new;
				best_ts_q <= rd.ts;
				best_ct_q <= rd.ct;
			end
		end
		if (state_q == S_PKWR) begin
			res_found_q <= 1'b1;
			res_slot_q <= 6'(best_idx_q);
		end
		if (out_load) begin
			out_q <= {1'b0, res_yield_q, res_old_q, res_found_q, res_slot_q};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("RAM written while idle");
	a_pick_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PKRD || state_q == S_PKWR) |-> best_v_q)
		else $error("pick marks a slot without a candidate");
	a_ev2_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV2) |-> $past(state_q) == S_EV1)
		else $error("evaluation step out of order");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result lost from output register");

endmodule
